FILE: rtl/fbc_pkg.sv
package fbc_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned TapIdxW = 5;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned ConvW   = 37;
  localparam int unsigned OutDataW = ((ConvW + 7) / 8) * 8;

  // Input item kinds carried on tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_EMIT
  } fbc_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_tap;    // write one kernel tap
    logic push;        // shift a sample into the delay line
    logic push_zero;   // shifted sample is zero (tail drain)
    logic clear_line;  // zero the whole delay line
    logic mac_en;      // form product for the current tap
    logic acc_clr;     // start a new sum
    logic out_load;    // move the sum into the output register
    logic out_last;    // flag of the sum being moved
  } fbc_cmd_t;

endpackage

FILE: rtl/fbc_ctrl.sv
module fbc_ctrl #(
  parameter int unsigned MaxTaps = 32,
  parameter int unsigned IdxW    = 5,
  parameter int unsigned CntW    = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  input  logic                  cfg_valid_i,
  input  logic [fbc_pkg::CfgW-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  input  logic                  out_free_i,
  output fbc_pkg::fbc_cmd_t     cmd_o,
  output logic [IdxW-1:0]       mac_idx_o
);
  import fbc_pkg::*;

  fbc_state_e        state_q, state_d;
  logic [CfgW-1:0]   tap_count_q;
  logic [CntW-1:0]   k_q, k_d, k_eff;
  logic [IdxW-1:0]   j_q, j_d;
  logic [IdxW-1:0]   rem_q, rem_d;
  logic              fin_q, fin_d;
  logic              accept, sample_go, last_tap, more_tail;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign sample_go   = accept && (in_op_i == OP_SAMPLE);
  assign last_tap    = ((CntW'(j_q) + CntW'(1)) == k_q);
  assign more_tail   = (rem_q != '0);
  assign mac_idx_o   = j_q;

  // Clamp the programmed tap count to 1..MaxTaps
  always_comb begin
    priority if (tap_count_q == '0) begin
      k_eff = CntW'(1);
    end else if ({1'b0, tap_count_q} > (CfgW + 1)'(MaxTaps)) begin
      k_eff = CntW'(MaxTaps);
    end else begin
      k_eff = CntW'(tap_count_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (sample_go) state_d = ST_MAC;
      ST_MAC:   if (last_tap) state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free_i) state_d = more_tail ? ST_MAC : ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    k_d   = k_q;
    j_d   = j_q;
    rem_d = rem_q;
    fin_d = fin_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_tap = accept && (in_op_i == OP_LOAD);
        if (sample_go) begin
          cmd_o.push    = 1'b1;
          cmd_o.acc_clr = 1'b1;
          k_d   = k_eff;
          j_d   = '0;
          fin_d = in_last_i;
          rem_d = in_last_i ? IdxW'(k_eff - CntW'(1)) : '0;
        end
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        j_d = j_q + IdxW'(1);
      end
      ST_FLUSH: begin
        cmd_o = '0;
      end
      ST_EMIT: begin
        cmd_o.out_last = fin_q && !more_tail;
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          if (more_tail) begin
            // next tail sum: feed a zero sample
            cmd_o.push      = 1'b1;
            cmd_o.push_zero = 1'b1;
            cmd_o.acc_clr   = 1'b1;
            j_d   = '0;
            rem_d = rem_q - IdxW'(1);
          end else begin
            cmd_o.clear_line = fin_q;
          end
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= CfgW'(1);
      k_q         <= CntW'(1);
      j_q         <= '0;
      rem_q       <= '0;
      fin_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      rem_q   <= rem_d;
      fin_q   <= fin_d;
      if (cfg_valid_i && cfg_ready_o) tap_count_q <= cfg_data_i;
    end
  end

endmodule

FILE: rtl/fbc_datapath.sv
module fbc_datapath #(
  parameter int unsigned MaxTaps    = 32,
  parameter int unsigned SampleBits = 16,
  parameter int unsigned IdxW       = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fbc_pkg::fbc_cmd_t                  cmd_i,
  input  logic [IdxW-1:0]                    mac_idx_i,
  input  logic [fbc_pkg::TapIdxW-1:0]        tap_index_i,
  input  logic signed [SampleBits-1:0]       value_i,
  output logic                               out_free_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [fbc_pkg::ConvW-1:0]   conv_value_o,
  output logic                               last_out_o
);
  import fbc_pkg::*;

  localparam int unsigned ProdW = 2 * SampleBits;

  logic signed [SampleBits-1:0] kernel_q [MaxTaps];
  logic signed [SampleBits-1:0] line_q   [MaxTaps];
  logic signed [ProdW-1:0]      prod_q;
  logic                         prod_vld_q;
  logic signed [63:0]           prod_ext;
  logic signed [ConvW-1:0]      acc_q;
  logic                         out_vld_q;
  logic signed [ConvW-1:0]      out_val_q;
  logic                         out_last_q;
  logic [TapIdxW+1:0]           wr_idx;
  logic                         wr_ok;

  assign wr_idx = (TapIdxW + 2)'(tap_index_i);
  assign wr_ok  = wr_idx < (TapIdxW + 2)'(MaxTaps);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTaps; i++) kernel_q[i] <= '0;
    end else if (cmd_i.load_tap && wr_ok) begin
      kernel_q[wr_idx[IdxW-1:0]] <= value_i;
    end
  end

  // Delay line: entry 0 is the newest sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxTaps; i++) line_q[i] <= '0;
    end else if (cmd_i.clear_line) begin
      for (int i = 0; i < MaxTaps; i++) line_q[i] <= '0;
    end else if (cmd_i.push) begin
      for (int i = MaxTaps - 1; i > 0; i--) line_q[i] <= line_q[i-1];
      line_q[0] <= cmd_i.push_zero ? '0 : value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) prod_q <= kernel_q[mac_idx_i] * line_q[mac_idx_i];
  end

  // Sum wraps at ConvW bits
  assign prod_ext = 64'(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prod_ext[ConvW-1:0];
    end
  end

  assign out_free_o = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_val_q  <= acc_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign conv_value_o = out_val_q;
  assign last_out_o   = out_last_q;

endmodule

FILE: rtl/fir_block_convolution.sv
// Full linear convolution of a sample stream with a kernel of up to MAX_TAPS
// signed taps. A load request (tuser = 0) writes one tap and leaves the input
// ready. A sample request (tuser = 1) shifts the sample into the delay line
// and yields one exact sum of products, wrapped to 37 bits; one shared
// multiplier walks the taps one per cycle, and the input is not ready again
// until the sum has moved to the output register. A sample marked tlast is
// followed by tap_count - 1 more sums fed by zeros, the final one carrying
// tlast, after which the delay line is zero again. Here tap_count is the
// clamped count, and every sum waits while the output is held. The output
// register holds one finished sum, so the next one is computed while the
// previous waits. tap_count is written on the cfg port while no request is
// in flight; 0 counts as 1 and values above MAX_TAPS count as MAX_TAPS.
module fir_block_convolution #(
  parameter int unsigned MAX_TAPS    = 32,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tap_index [4:0], value [SAMPLE_BITS+4:5], zero fill above
  input  logic [((fbc_pkg::TapIdxW + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // op: 0 = load tap, 1 = sample
  input  logic                                 s_axis_tuser_i,
  input  logic                                 s_axis_tlast_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // conv_value [36:0], zero fill above
  output logic [fbc_pkg::OutDataW-1:0]         m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fbc_pkg::CfgW-1:0]             cfg_data_i
);
  import fbc_pkg::*;

  localparam int unsigned IdxW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TAPS + 1);

  fbc_cmd_t                  cmd;
  logic [IdxW-1:0]           mac_idx;
  logic                      out_free;
  logic signed [ConvW-1:0]   conv_value;

  fbc_ctrl #(
    .MaxTaps (MAX_TAPS),
    .IdxW    (IdxW),
    .CntW    (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_op_i     (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .out_free_i  (out_free),
    .cmd_o       (cmd),
    .mac_idx_o   (mac_idx)
  );

  fbc_datapath #(
    .MaxTaps    (MAX_TAPS),
    .SampleBits (SAMPLE_BITS),
    .IdxW       (IdxW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mac_idx_i    (mac_idx),
    .tap_index_i  (s_axis_tdata_i[TapIdxW-1:0]),
    .value_i      (s_axis_tdata_i[TapIdxW +: SAMPLE_BITS]),
    .out_free_o   (out_free),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .conv_value_o (conv_value),
    .last_out_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutDataW'(unsigned'(conv_value));

endmodule

FILE: rtl/fbc_checker.sv
module fbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);
  import fbc_pkg::*;

  logic in_acc;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Busy with the sum once a sample request is taken
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == OP_SAMPLE) |=> !s_axis_tready_o)
    else $error("input ready right after a sample request");

  // Tap loads never stall the input
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == OP_LOAD) |=> s_axis_tready_o)
    else $error("input stalled after a tap load");

  // No sum can be ready in the cycle after its sample is taken
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == OP_SAMPLE) |=> !$rose(m_axis_tvalid_o))
    else $error("result shown too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind fir_block_convolution fbc_checker u_fbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: tb/sv/tb_fir_block_convolution.sv
module tb_fir_block_convolution;

  localparam int unsigned MAX_TAPS    = 32;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned HistDepth   = MAX_TAPS - 1;
  localparam int unsigned SDataW      = ((fbc_pkg::TapIdxW + SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned ConvW       = fbc_pkg::ConvW;
  localparam int unsigned SettleCycles = 2 * (MAX_TAPS + 3) + 10;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned RandomItems  = 500;

  typedef struct packed {
    logic                          op;
    logic [fbc_pkg::TapIdxW-1:0]   tap_idx;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;
  } fir_req_t;

  typedef struct packed {
    logic signed [ConvW-1:0] conv_value;
    logic                    last_out;
  } conv_res_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [SDataW-1:0]              s_axis_tdata_i = '0;
  logic                           s_axis_tuser_i = 1'b0;
  logic                           s_axis_tlast_i = 1'b0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [fbc_pkg::OutDataW-1:0]   m_axis_tdata_o;
  logic                           m_axis_tlast_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [fbc_pkg::CfgW-1:0]       cfg_data_i = '0;

  fir_req_t  pending_reqs[$];
  conv_res_t expected_sums[$];

  // predictor state
  logic signed [SAMPLE_BITS-1:0] kern_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_q [HistDepth];
  logic [fbc_pkg::CfgW-1:0]      tap_count_q = 6'd1;

  int unsigned err_count = 0;
  int unsigned items_queued = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  fir_block_convolution #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  function automatic int unsigned active_taps();
    if (tap_count_q == 0) return 1;
    if (tap_count_q > MAX_TAPS) return MAX_TAPS;
    return tap_count_q;
  endfunction

  // Sum with x as newest sample, then shift x into the delay line.
  function automatic logic signed [ConvW-1:0] shift_and_sum(
      input logic signed [SAMPLE_BITS-1:0] x, input int unsigned k);
    logic signed [ConvW-1:0] acc;
    acc = kern_q[0] * x;
    for (int unsigned j = 1; j < k; j++) acc = acc + kern_q[j] * hist_q[j-1];
    for (int j = HistDepth - 1; j > 0; j--) hist_q[j] = hist_q[j-1];
    hist_q[0] = x;
    return acc;
  endfunction

  task automatic predict_request(input fir_req_t req);
    int unsigned k;
    logic signed [ConvW-1:0] sum;
    if (req.op == fbc_pkg::OP_LOAD) begin
      if (req.tap_idx < MAX_TAPS) kern_q[req.tap_idx] = req.value;
      return;
    end
    k = active_taps();
    sum = shift_and_sum(req.value, k);
    expected_sums.push_back('{conv_value: sum, last_out: req.last && k == 1});
    if (req.last) begin
      for (int unsigned t = 1; t < k; t++) begin
        sum = shift_and_sum('0, k);
        expected_sums.push_back('{conv_value: sum, last_out: t == k - 1});
      end
      foreach (hist_q[j]) hist_q[j] = '0;
    end
  endtask

  // Sender: hold a request until taken, then wait the drawn gap.
  always @(posedge clk_i) begin
    fir_req_t req;
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req = pending_reqs.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i <= req.op;
        s_axis_tlast_i <= req.last;
        s_axis_tdata_i <= SDataW'({req.value, req.tap_idx});
        tx_gap <= tx_burst ? 0 : $urandom_range(0, 10);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall per result, plus a long hold-off on demand.
  always @(posedge clk_i) begin
    int unsigned w;
    if (rst_ni) begin
      if (hold_requests != hold_served) begin
        hold_served <= hold_requests;
        hold_left <= HoldCycles;
        m_axis_tready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= (hold_left == 1);
      end else if (m_axis_tvalid_o && m_axis_tready_i) begin
        w = rx_burst ? 0 : $urandom_range(0, 10);
        rx_wait <= w;
        m_axis_tready_i <= (w == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        m_axis_tready_i <= (rx_wait == 1);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Check results, track config, predict, and watch for a hang.
  always @(posedge clk_i) begin
    conv_res_t want;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        moved = 1'b1;
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected",
                                    $signed(m_axis_tdata_o[ConvW-1:0])));
        end else begin
          want = expected_sums.pop_front();
          if (m_axis_tdata_o[ConvW-1:0] !== want.conv_value)
            report_mismatch($sformatf("conv_value %0d, want %0d",
                                      $signed(m_axis_tdata_o[ConvW-1:0]),
                                      want.conv_value));
          if (m_axis_tlast_o !== want.last_out)
            report_mismatch($sformatf("last_out %b, want %b",
                                      m_axis_tlast_o, want.last_out));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        tap_count_q = cfg_data_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        moved = 1'b1;
        predict_request(fir_req_t'({s_axis_tuser_i,
                                    s_axis_tdata_i[fbc_pkg::TapIdxW-1:0],
                                    s_axis_tdata_i[fbc_pkg::TapIdxW +: SAMPLE_BITS],
                                    s_axis_tlast_i}));
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("stalled for %0d cycles", StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic op, input logic [4:0] idx,
                            input logic signed [SAMPLE_BITS-1:0] val, input logic last);
    pending_reqs.push_back('{op: op, tap_idx: idx, value: val, last: last});
    items_queued++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Hold until every request is taken and every sum has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid_i || expected_sums.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_tap_count(input logic [fbc_pkg::CfgW-1:0] n);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned n_samp;
    logic [fbc_pkg::CfgW-1:0] n;
    bit end_signal;

    foreach (kern_q[j]) kern_q[j] = '0;
    foreach (hist_q[j]) hist_q[j] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one tap: zero kernel, then extremes; single tap with last
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, 16'sd12345, 1'b0);
    queue_item(fbc_pkg::OP_LOAD, 5'd0, -16'sd32768, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, -16'sd32768, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, 16'sd32767, 1'b1);

    write_tap_count(6'd4);
    queue_item(fbc_pkg::OP_LOAD, 5'd1, 16'sd32767, 1'b0);
    queue_item(fbc_pkg::OP_LOAD, 5'd2, -16'sd1, 1'b0);
    queue_item(fbc_pkg::OP_LOAD, 5'd3, 16'sd21845, 1'b1);  // last ignored on load
    queue_item(fbc_pkg::OP_LOAD, 5'd31, -16'sd32768, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd31, -16'sd32768, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, 16'sd32767, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, -16'sd1, 1'b1);

    write_tap_count(6'd0);   // counts as one tap
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, 16'sd32767, 1'b1);

    write_tap_count(6'd63);  // saturates to the full kernel
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, -16'sd32768, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, -16'sd32768, 1'b1);

    // count changed while a signal is in the delay line
    write_tap_count(6'd2);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, 16'sd100, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, -16'sd7, 1'b0);
    write_tap_count(6'd5);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, -16'sd200, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, 16'sd300, 1'b1);

    write_tap_count(6'd32);
    queue_item(fbc_pkg::OP_LOAD, 5'd17, 16'sd10922, 1'b0);
    queue_item(fbc_pkg::OP_SAMPLE, 5'd0, 16'sd32767, 1'b1);

    items_queued = 0;
    phase = 0;
    while (items_queued < RandomItems) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1:    n = 6'($urandom_range(0, 63));
        2:       n = 6'(MAX_TAPS);
        3, 4:    n = 6'($urandom_range(9, 31));
        default: n = 6'($urandom_range(1, 8));
      endcase
      if (phase == 2) begin
        // flood the input while the output is held off
        write_tap_count(6'd3);
        tx_burst = 1'b1;
        hold_requests++;
        for (int unsigned i = 0; i < 30; i++)
          queue_item(fbc_pkg::OP_SAMPLE, 5'($urandom), rand_value(), i == 29);
      end else begin
        write_tap_count(n);
        repeat ($urandom_range(0, 6))
          queue_item(fbc_pkg::OP_LOAD, 5'($urandom), rand_value(), 1'($urandom));
        n_samp = $urandom_range(1, 20);
        end_signal = ($urandom_range(0, 6) != 0);
        for (int unsigned i = 0; i < n_samp; i++) begin
          if ($urandom_range(0, 9) == 0)
            queue_item(fbc_pkg::OP_LOAD, 5'($urandom), rand_value(), 1'($urandom));
          queue_item(fbc_pkg::OP_SAMPLE, 5'($urandom), rand_value(),
                     end_signal && i == n_samp - 1);
        end
      end
      phase++;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: fir_block_convolution.f
rtl/fbc_pkg.sv
rtl/fbc_ctrl.sv
rtl/fbc_datapath.sv
rtl/fir_block_convolution.sv
rtl/fbc_checker.sv
tb/sv/tb_fir_block_convolution.sv
